@@ rtl/lpm_pkg.sv @@
package lpm_pkg;

  // Pattern storage is fixed at sixteen bytes by the register layout.
  localparam int PATTERN_BYTES = 16;
  localparam int PATTERN_W     = 8 * PATTERN_BYTES;
  localparam int BYTE_SEL_W    = 4;
  localparam int LEN_W         = 5;
  localparam int OUT_COUNT_W   = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_CASE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WHOLE_WORD     = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_COMMA    = 8'h2C;
  localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
  localparam logic [7:0] CHAR_BANG     = 8'h21;
  localparam logic [7:0] CHAR_HYPHEN   = 8'h2D;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  // Control handed from the top level to every cell of the chain.
  typedef struct packed {
    logic step;
    logic newline;
    logic ignore_case;
  } cell_ctrl_t;

  // Control handed from the top level to the token tracker.
  typedef struct packed {
    logic step;
    logic delim;
    logic ignore_case;
  } token_ctrl_t;

  // Folds an ASCII upper case letter to lower case when asked to.
  function automatic logic [7:0] fold_case(input logic [7:0] c, input logic ign);
    logic [7:0] r;
    r = c;
    if (ign && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  // Word separators, newline included.
  function automatic logic is_delimiter(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_COMMA) || (c == CHAR_PERIOD) ||
           (c == CHAR_BANG) || (c == CHAR_HYPHEN) || (c == CHAR_QUESTION) ||
           (c == CHAR_COLON) || (c == CHAR_NEWLINE);
  endfunction

endpackage

@@ rtl/lpm_if.sv @@
// Text channel: one byte of the stream per word.
interface lpm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       file_start;

  modport source(output valid, output text_byte, output file_start, input ready);
  modport sink(input valid, input text_byte, input file_start, output ready);
endinterface

// Result channel: one word per ended line.
interface lpm_result_if;
  logic                             valid;
  logic                             ready;
  logic [lpm_pkg::OUT_COUNT_W-1:0]  line_number;
  logic                             line_hit;
  logic [lpm_pkg::OUT_COUNT_W-1:0]  hit_count;
  logic                             any_hit;

  modport source(output valid, output line_number, output line_hit,
                 output hit_count, output any_hit, input ready);
  modport sink(input valid, input line_number, input line_hit,
               input hit_count, input any_hit, output ready);
endinterface

// Configuration write channel.
interface lpm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpm_pkg::CFG_INDEX_W-1:0]  index;
  logic [lpm_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/lpm_cell.sv @@
// One position of the shift-and chain. The cell holds whether the line so
// far ends in the pattern prefix up to and including its own byte, and
// hands that bit on to the next cell.
module lpm_cell (
  input  logic                clk,
  input  logic                rst,
  input  lpm_pkg::cell_ctrl_t ctrl,
  input  logic                enable,
  input  logic                last,
  input  logic [7:0]          pattern_byte,
  input  logic [7:0]          folded_byte,
  input  logic                carry_in,
  output logic                carry_out,
  output logic                tail_hit
);

  logic match;
  logic match_next;

  // Prefix extends when the neighbour matched and this byte agrees.
  assign match_next = enable && carry_in &&
                      (lpm_pkg::fold_case(pattern_byte, ctrl.ignore_case) == folded_byte);

  // The last cell in use reports a full pattern match.
  assign tail_hit  = last && match_next;
  assign carry_out = match;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.step) begin
      match <= ctrl.newline ? 1'b0 : match_next;
    end
  end

endmodule

@@ rtl/lpm_token.sv @@
// Tracks the current delimited token and whether it still equals the
// pattern, for the whole-word compare.
module lpm_token (
  input  logic                           clk,
  input  logic                           rst,
  input  lpm_pkg::token_ctrl_t           ctrl,
  input  logic [7:0]                     folded_byte,
  input  logic [lpm_pkg::PATTERN_W-1:0]  pattern,
  input  logic [lpm_pkg::LEN_W-1:0]      used_len,
  output logic                           token_hit
);

  localparam logic [lpm_pkg::LEN_W-1:0] LEN_SAT = '1;

  logic [lpm_pkg::LEN_W-1:0] token_length;
  logic                      token_still_equal;
  logic [7:0]                pattern_byte;
  logic                      mismatch;

  // Pattern byte at the current token position.
  assign pattern_byte = pattern[8*token_length[lpm_pkg::BYTE_SEL_W-1:0] +: 8];
  assign mismatch     = (token_length >= used_len) ||
                        (lpm_pkg::fold_case(pattern_byte, ctrl.ignore_case) != folded_byte);

  // The token so far is the whole pattern.
  assign token_hit = token_still_equal && (token_length == used_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_length      <= '0;
      token_still_equal <= 1'b1;
    end else if (ctrl.step) begin
      if (ctrl.delim) begin
        token_length      <= '0;
        token_still_equal <= 1'b1;
      end else begin
        if (mismatch) begin
          token_still_equal <= 1'b0;
        end
        if (token_length != LEN_SAT) begin
          token_length <= token_length + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/line_pattern_matcher.sv @@
// A line's result word is offered in the cycle after its newline byte is taken.
// Throughput: one text byte per cycle; the chain of match cells and the token
// tracker both update on every byte taken, and a byte is taken in the same cycle as a waiting
// result word leaves, while a stalled result word holds the input back. Synchronous
// reset clears the pattern to zero, the length to one, modes, chain, token and counters.
module line_pattern_matcher #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  lpm_text_if.sink            text,
  lpm_result_if.source        result,
  lpm_cfg_if.sink             cfg
);

  localparam int LEN_W = lpm_pkg::LEN_W;
  localparam int OCW   = lpm_pkg::OUT_COUNT_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

  // Configuration registers.
  logic [lpm_pkg::PATTERN_W-1:0] pattern;
  logic [LEN_W-1:0]              pattern_length;
  logic                          ignore_case;
  logic                          whole_word;

  // Line state and counters.
  logic                   current_line_hit;
  logic [COUNT_WIDTH-1:0] lines_seen;
  logic [COUNT_WIDTH-1:0] matching_lines;
  logic [COUNT_WIDTH-1:0] lines_base;
  logic [COUNT_WIDTH-1:0] matching_base;
  logic [COUNT_WIDTH-1:0] lines_next;
  logic [COUNT_WIDTH-1:0] matching_next;
  logic [OCW-1:0]         lines_out;
  logic [OCW-1:0]         matching_out;

  // Output register.
  logic           out_valid;
  logic [OCW-1:0] out_line_number;
  logic           out_line_hit;
  logic [OCW-1:0] out_hit_count;
  logic           out_any_hit;

  logic                   text_acc;
  logic                   newline;
  logic                   delim;
  logic [7:0]             folded_byte;
  logic [LEN_W-1:0]       used_len;
  logic [PATTERN_MAX:0]   chain;
  logic [PATTERN_MAX-1:0] tail_hits;
  logic                   tail_any;
  logic                   token_hit;
  logic                   line_hit_now;
  lpm_pkg::cell_ctrl_t    cell_ctrl;
  lpm_pkg::token_ctrl_t   token_ctrl;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= LEN_W'(1);
      ignore_case    <= 1'b0;
      whole_word     <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        lpm_pkg::REG_PATTERN_LOW:    pattern[63:0]   <= cfg.data;
        lpm_pkg::REG_PATTERN_HIGH:   pattern[127:64] <= cfg.data;
        lpm_pkg::REG_PATTERN_LENGTH: pattern_length  <= cfg.data[LEN_W-1:0];
        lpm_pkg::REG_IGNORE_CASE:    ignore_case     <= cfg.data[0];
        lpm_pkg::REG_WHOLE_WORD:     whole_word      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Length in use, clamped to the range the chain supports.
  always_comb begin
    if (pattern_length == '0) begin
      used_len = LEN_W'(1);
    end else if (pattern_length > LEN_MAX) begin
      used_len = LEN_MAX;
    end else begin
      used_len = pattern_length;
    end
  end

  // Input handshake and byte classification.
  assign text.ready  = !out_valid || result.ready;
  assign text_acc    = text.valid && text.ready;
  assign newline     = (text.text_byte == lpm_pkg::CHAR_NEWLINE);
  assign delim       = lpm_pkg::is_delimiter(text.text_byte);
  assign folded_byte = lpm_pkg::fold_case(text.text_byte, ignore_case);

  assign cell_ctrl.step         = text_acc;
  assign cell_ctrl.newline      = newline;
  assign cell_ctrl.ignore_case  = ignore_case;
  assign token_ctrl.step        = text_acc;
  assign token_ctrl.delim       = delim;
  assign token_ctrl.ignore_case = ignore_case;

  // Chain of match cells; the first cell always sees an open prefix.
  assign chain[0] = 1'b1;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    lpm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cell_ctrl),
      .enable       (LEN_W'(g) < used_len),
      .last         (LEN_W'(g + 1) == used_len),
      .pattern_byte (pattern[8*g +: 8]),
      .folded_byte  (folded_byte),
      .carry_in     (chain[g]),
      .carry_out    (chain[g+1]),
      .tail_hit     (tail_hits[g])
    );
  end

  assign tail_any = |tail_hits;

  // Whole-word token tracker.
  lpm_token u_token (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (token_ctrl),
    .folded_byte (folded_byte),
    .pattern     (pattern),
    .used_len    (used_len),
    .token_hit   (token_hit)
  );

  // Line verdict at a newline, counter updates with saturation.
  assign line_hit_now  = current_line_hit || (whole_word && token_hit);
  assign lines_base    = text.file_start ? '0 : lines_seen;
  assign matching_base = text.file_start ? '0 : matching_lines;

  always_comb begin
    lines_next    = lines_base;
    matching_next = matching_base;
    if (newline && lines_base != '1) begin
      lines_next = lines_base + 1'b1;
    end
    if (newline && line_hit_now && matching_base != '1) begin
      matching_next = matching_base + 1'b1;
    end
  end

  if (COUNT_WIDTH >= OCW) begin : g_wide
    assign lines_out    = lines_next[OCW-1:0];
    assign matching_out = matching_next[OCW-1:0];
  end else begin : g_narrow
    assign lines_out    = OCW'(lines_next);
    assign matching_out = OCW'(matching_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_line_hit <= 1'b0;
      lines_seen       <= '0;
      matching_lines   <= '0;
    end else if (text_acc) begin
      lines_seen     <= lines_next;
      matching_lines <= matching_next;
      if (newline) begin
        current_line_hit <= 1'b0;
      end else if ((!whole_word && tail_any) || (whole_word && delim && token_hit)) begin
        current_line_hit <= 1'b1;
      end
    end
  end

  // Output register holding one result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (text_acc && newline) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc && newline) begin
      out_line_number <= lines_out;
      out_line_hit    <= line_hit_now;
      out_hit_count   <= matching_out;
      out_any_hit     <= (matching_next != '0);
    end
  end

  assign result.valid       = out_valid;
  assign result.line_number = out_line_number;
  assign result.line_hit    = out_line_hit;
  assign result.hit_count   = out_hit_count;
  assign result.any_hit     = out_any_hit;

  // A new result word appears only after a newline was taken.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(text_acc && newline))
    else $error("result word without a newline");

  // Matching lines can never outnumber the lines seen.
  assert property (@(posedge clk) disable iff (rst)
    matching_lines <= lines_seen)
    else $error("hit count exceeds line count");

  // A hit line always leaves the any-hit flag set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_line_hit |-> out_any_hit)
    else $error("line hit without any-hit");

  // The match chain and line hit are cleared by every newline.
  assert property (@(posedge clk) disable iff (rst)
    text_acc && newline |=> (chain[PATTERN_MAX:1] == '0) && !current_line_hit)
    else $error("line state not cleared at newline");

endmodule

@@ bench/tb_line_pattern_matcher.sv @@
module tb_line_pattern_matcher;

  localparam int RANDOM_BYTES   = 2000;
  localparam int SETTLE_CYCLES  = 3;
  localparam int TAIL_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [lpm_pkg::OUT_COUNT_W-1:0] line_number;
    logic                            line_hit;
    logic [lpm_pkg::OUT_COUNT_W-1:0] hit_count;
    logic                            any_hit;
  } line_result_t;

  typedef struct {
    logic                            is_cfg;
    logic [lpm_pkg::CFG_INDEX_W-1:0] idx;
    logic [lpm_pkg::CFG_DATA_W-1:0]  data;
    logic [7:0]                      ch;
    logic                            fs;
    logic                            typed;
    line_result_t                    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  lpm_text_if   text_bus ();
  lpm_result_if result_bus ();
  lpm_cfg_if    cfg_bus ();

  line_pattern_matcher i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #5 clk = ~clk;

  // Register copies held by the bench.
  logic [63:0] pat_lo      = '0;
  logic [63:0] pat_hi      = '0;
  logic [4:0]  pat_len_raw = 5'd1;
  logic        fold_on     = 1'b0;
  logic        word_mode   = 1'b0;

  // Matcher state held by the bench.
  logic [15:0]                     prefix_hits   = '0;
  logic [4:0]                      token_len     = '0;
  logic                            token_equal   = 1'b1;
  logic                            line_seen_hit = 1'b0;
  logic [lpm_pkg::OUT_COUNT_W-1:0] file_lines    = '0;
  logic [lpm_pkg::OUT_COUNT_W-1:0] file_hits     = '0;

  line_result_t expected_lines[$];
  stim_row_t    directed_rows[$];
  int           mismatches = 0;
  int           gap_pct    = 21;
  int           stall_pct  = 56;
  int           bytes_sent = 0;

  // Side band that travels with each text word: a typed-in expectation, if any.
  logic         row_typed = 1'b0;
  line_result_t row_typed_result = '0;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (fold_on && c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_char(input int i);
    logic [127:0] all_bytes;
    all_bytes = {pat_hi, pat_lo};
    return all_bytes[i*8 +: 8];
  endfunction

  function automatic int used_len();
    int len;
    len = pat_len_raw;
    if (len == 0) begin
      len = 1;
    end
    if (len > lpm_pkg::PATTERN_BYTES) begin
      len = lpm_pkg::PATTERN_BYTES;
    end
    return len;
  endfunction

  function automatic logic separator_char(input logic [7:0] c);
    return c == lpm_pkg::CHAR_SPACE || c == lpm_pkg::CHAR_COMMA ||
           c == lpm_pkg::CHAR_PERIOD || c == lpm_pkg::CHAR_BANG ||
           c == lpm_pkg::CHAR_HYPHEN || c == lpm_pkg::CHAR_QUESTION ||
           c == lpm_pkg::CHAR_COLON || c == lpm_pkg::CHAR_NEWLINE;
  endfunction

  task automatic apply_reg(input logic [lpm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lpm_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      lpm_pkg::REG_PATTERN_LOW:    pat_lo = value;
      lpm_pkg::REG_PATTERN_HIGH:   pat_hi = value;
      lpm_pkg::REG_PATTERN_LENGTH: pat_len_raw = value[4:0];
      lpm_pkg::REG_IGNORE_CASE:    fold_on = value[0];
      lpm_pkg::REG_WHOLE_WORD:     word_mode = value[0];
      default: ;
    endcase
  endtask

  // Advances the line matcher by one text byte and queues the line result on a newline.
  task automatic scan_text_byte(input logic [7:0] c, input logic fs, input logic typed,
                                input line_result_t typed_res);
    int           len;
    logic [15:0]  shifted;
    logic [15:0]  nxt;
    logic [7:0]   fc;
    logic         hit;
    line_result_t r;
    len = used_len();
    if (fs) begin
      file_lines = '0;
      file_hits  = '0;
    end
    if (c == lpm_pkg::CHAR_NEWLINE) begin
      hit = line_seen_hit || (word_mode && token_equal && token_len == len);
      if (file_lines != '1) begin
        file_lines++;
      end
      if (hit && file_hits != '1) begin
        file_hits++;
      end
      r.line_number = file_lines;
      r.line_hit    = hit;
      r.hit_count   = file_hits;
      r.any_hit     = file_hits != '0;
      expected_lines = {expected_lines, (typed ? typed_res : r)};
      prefix_hits   = '0;
      token_len     = '0;
      token_equal   = 1'b1;
      line_seen_hit = 1'b0;
    end else begin
      // Shift-and over the pattern prefixes.
      fc      = fold_char(c);
      shifted = {prefix_hits[14:0], 1'b1};
      nxt     = '0;
      for (int i = 0; i < len; i++) begin
        if (shifted[i] && fold_char(pattern_char(i)) == fc) begin
          nxt[i] = 1'b1;
        end
      end
      prefix_hits = nxt;
      if (!word_mode && nxt[len-1]) begin
        line_seen_hit = 1'b1;
      end
      // Token compare for whole-word mode.
      if (separator_char(c)) begin
        if (word_mode && token_equal && token_len == len) begin
          line_seen_hit = 1'b1;
        end
        token_len   = '0;
        token_equal = 1'b1;
      end else begin
        if (token_len >= len || fold_char(pattern_char(token_len[3:0])) != fc) begin
          token_equal = 1'b0;
        end
        if (token_len != 5'd31) begin
          token_len++;
        end
      end
    end
  endtask

  // Observe every accepted word at the clock edge.
  always @(posedge clk) begin : observe
    line_result_t want;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_lines.size() == 0) begin
          $error("unexpected result word: line_number %0d", result_bus.line_number);
          mismatches++;
        end else begin
          want = expected_lines.pop_front();
          if (result_bus.line_number !== want.line_number) begin
            $error("line_number: expected %0d, got %0d", want.line_number,
                   result_bus.line_number);
            mismatches++;
          end
          if (result_bus.line_hit !== want.line_hit) begin
            $error("line_hit: expected %0b, got %0b", want.line_hit, result_bus.line_hit);
            mismatches++;
          end
          if (result_bus.hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, got %0d", want.hit_count, result_bus.hit_count);
            mismatches++;
          end
          if (result_bus.any_hit !== want.any_hit) begin
            $error("any_hit: expected %0b, got %0b", want.any_hit, result_bus.any_hit);
            mismatches++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        apply_reg(cfg_bus.index, cfg_bus.data);
      end
      if (text_bus.valid && text_bus.ready) begin
        scan_text_byte(text_bus.text_byte, text_bus.file_start, row_typed, row_typed_result);
      end
    end
  end

  // Result receiver stalls at random.
  always @(posedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // The run ends if nothing at all is accepted for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((text_bus.valid && text_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("line_pattern_matcher: mismatch");
    $finish;
  end

  task automatic send_text(input logic [7:0] ch, input logic fs, input logic typed,
                           input line_result_t res);
    while ($urandom_range(99) < gap_pct) begin
      text_bus.valid <= 1'b0;
      @(posedge clk);
    end
    text_bus.valid      <= 1'b1;
    text_bus.text_byte  <= ch;
    text_bus.file_start <= fs;
    row_typed           <= typed;
    row_typed_result    <= res;
    do @(posedge clk); while (!text_bus.ready);
  endtask

  task automatic write_reg(input logic [lpm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lpm_pkg::CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Holds the sender back until every outstanding line result has come out.
  task automatic drain_results();
    text_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_lines.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_cfg(input logic [lpm_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [lpm_pkg::CFG_DATA_W-1:0] value);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = value;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_text(input logic [7:0] ch, input logic fs);
    stim_row_t row;
    row    = '{default: '0};
    row.ch = ch;
    row.fs = fs;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_line_end(input logic fs, input int ln, input logic hit, input int cnt,
                              input logic any);
    stim_row_t row;
    row                 = '{default: '0};
    row.ch              = lpm_pkg::CHAR_NEWLINE;
    row.fs              = fs;
    row.typed           = 1'b1;
    row.res.line_number = ln;
    row.res.line_hit    = hit;
    row.res.hit_count   = cnt;
    row.res.any_hit     = any;
    directed_rows = {directed_rows, row};
  endtask

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(6))
      0: return lpm_pkg::CHAR_SPACE;
      1: return lpm_pkg::CHAR_COMMA;
      2: return lpm_pkg::CHAR_PERIOD;
      3: return lpm_pkg::CHAR_BANG;
      4: return lpm_pkg::CHAR_HYPHEN;
      5: return lpm_pkg::CHAR_QUESTION;
      default: return lpm_pkg::CHAR_COLON;
    endcase
  endfunction

  // A letter from a narrow alphabet, in either case, so that hits stay frequent.
  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'($urandom_range("a", "h"));
    if ($urandom_range(1) == 1) begin
      c = c - 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return pick_letter();
    end else if (r < 80) begin
      return pick_separator();
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic set_idling();
    if (bytes_sent < RANDOM_BYTES / 3) begin
      gap_pct   = 21;
      stall_pct = 56;
    end else if (bytes_sent < 2 * RANDOM_BYTES / 3) begin
      gap_pct   = 56;
      stall_pct = 21;
    end else begin
      gap_pct   = 0;
      stall_pct = 0;
    end
  endtask

  // Writes every register; the first phases take the extreme settings.
  task automatic program_phase(input int phase);
    logic [127:0]                    pat;
    logic [4:0]                      len;
    logic                            ign;
    logic                            ww;
    logic [63:0]                     junk;
    logic [lpm_pkg::CFG_INDEX_W-1:0] spare;
    int                              r;
    for (int i = 0; i < lpm_pkg::PATTERN_BYTES; i++) begin
      pat[i*8 +: 8] = pick_pattern_char();
    end
    r = $urandom_range(99);
    if (r < 80) begin
      len = 5'($urandom_range(1, 6));
    end else if (r < 90) begin
      len = 5'd16;
    end else if (r < 95) begin
      len = 5'd0;
    end else begin
      len = 5'($urandom_range(17, 31));
    end
    ign = 1'($urandom_range(1));
    ww  = 1'($urandom_range(1));
    case (phase)
      0: begin
        pat = '1;
        len = 5'd16;
        ign = 1'b1;
        ww  = 1'b1;
      end
      1: begin
        pat = '0;
        len = 5'd31;
        ign = 1'b0;
        ww  = 1'b0;
      end
      2: begin
        len = 5'd0;
        ww  = 1'b1;
      end
      default: ;
    endcase
    junk  = ($urandom_range(9) < 3) ? {$urandom, $urandom} : 64'd0;
    spare = lpm_pkg::REG_WHOLE_WORD + 3'd1 + 3'($urandom_range(2));
    drain_results();
    write_reg(lpm_pkg::REG_PATTERN_LOW, pat[63:0]);
    write_reg(lpm_pkg::REG_PATTERN_HIGH, pat[127:64]);
    write_reg(lpm_pkg::REG_PATTERN_LENGTH, {junk[63:5], len});
    write_reg(lpm_pkg::REG_IGNORE_CASE, {junk[63:1], ign});
    write_reg(lpm_pkg::REG_WHOLE_WORD, {junk[63:1], ww});
    if ($urandom_range(9) == 0) begin
      write_reg(spare, {$urandom, $urandom});
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Builds one line from pattern copies, near misses, words and noise, then sends it.
  task automatic send_random_line();
    logic [7:0] line_q[$];
    logic [7:0] c;
    int         tokens;
    int         kind;
    int         len;
    int         n;
    len    = used_len();
    tokens = $urandom_range(0, 6);
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        for (int i = 0; i < len; i++) begin
          c = pattern_char(i);
          if ($urandom_range(99) < (fold_on ? 50 : 10)) begin
            c = flip_case(c);
          end
          line_q = {line_q, c};
        end
      end else if (kind < 40) begin
        n = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
          if (!(n == 0 && i == len - 1 && len > 1)) begin
            line_q = {line_q, pattern_char(i)};
          end
        end
        if (n == 1) begin
          line_q = {line_q, pick_letter()};
        end else if (n == 2) begin
          line_q[line_q.size() - 1 - $urandom_range(len - 1)] = pick_letter();
        end
      end else if (kind < 65) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          c = $urandom_range(1) ? pattern_char($urandom_range(len - 1)) : pick_letter();
          line_q = {line_q, c};
        end
      end else if (kind < 80) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          line_q = {line_q, 8'($urandom_range(255))};
        end
      end
      if (t != tokens - 1 || $urandom_range(9) < 2) begin
        line_q = {line_q, pick_separator()};
        if ($urandom_range(9) == 0) begin
          line_q = {line_q, pick_separator()};
        end
      end
    end
    line_q = {line_q, lpm_pkg::CHAR_NEWLINE};
    foreach (line_q[i]) begin
      send_text(line_q[i], $urandom_range(99) < 2, 1'b0, '0);
      bytes_sent++;
      set_idling();
    end
  endtask

  // Directed stimulus table.
  task automatic build_directed();
    // After reset the pattern is a single zero byte.
    add_line_end(1'b0, 1, 1'b0, 0, 1'b0);
    add_text(8'h00, 1'b0);
    add_line_end(1'b0, 2, 1'b1, 1, 1'b1);
    // File start clears the counters before the byte is taken.
    add_text(8'hFF, 1'b1);
    add_line_end(1'b0, 1, 1'b0, 0, 1'b0);
    // Substring match with case folding.
    add_cfg(lpm_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_6241);
    add_cfg(lpm_pkg::REG_PATTERN_LENGTH, 64'd2);
    add_cfg(lpm_pkg::REG_IGNORE_CASE, 64'd1);
    add_text("x", 1'b0);
    add_text("a", 1'b0);
    add_text("B", 1'b0);
    add_text(lpm_pkg::CHAR_NEWLINE, 1'b0);
    // Whole words, an empty token, then a mode change part way through a line.
    add_cfg(lpm_pkg::REG_WHOLE_WORD, 64'd1);
    add_text("A", 1'b0);
    add_text("b", 1'b0);
    add_text(lpm_pkg::CHAR_COMMA, 1'b0);
    add_text(lpm_pkg::CHAR_COMMA, 1'b0);
    add_text("a", 1'b0);
    add_cfg(lpm_pkg::REG_IGNORE_CASE, 64'd0);
    add_text("b", 1'b0);
    add_text(lpm_pkg::CHAR_NEWLINE, 1'b0);
    // Length zero acts as one; file start on the newline itself.
    add_cfg(lpm_pkg::REG_PATTERN_LOW, '1);
    add_cfg(lpm_pkg::REG_PATTERN_HIGH, '1);
    add_cfg(lpm_pkg::REG_PATTERN_LENGTH, 64'd0);
    add_cfg(lpm_pkg::REG_WHOLE_WORD, 64'd0);
    add_text(8'hFF, 1'b0);
    add_line_end(1'b1, 1, 1'b1, 1, 1'b1);
    // A newline in the pattern can never match.
    add_cfg(lpm_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_000A);
    add_cfg(lpm_pkg::REG_PATTERN_LENGTH, 64'd1);
    add_text(lpm_pkg::CHAR_NEWLINE, 1'b0);
    add_text("q", 1'b0);
    add_text(lpm_pkg::CHAR_NEWLINE, 1'b0);
  endtask

  initial begin
    logic in_cfg;
    int   phase;
    int   phase_end;
    rst                 = 1'b1;
    text_bus.valid      = 1'b0;
    text_bus.text_byte  = '0;
    text_bus.file_start = 1'b0;
    result_bus.ready    = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    build_directed();
    in_cfg = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!in_cfg) begin
          drain_results();
        end
        in_cfg = 1'b1;
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        if (in_cfg) begin
          cfg_bus.valid <= 1'b0;
        end
        in_cfg = 1'b0;
        send_text(directed_rows[i].ch, directed_rows[i].fs, directed_rows[i].typed,
                  directed_rows[i].res);
      end
    end

    // Random phases, each with its own register settings.
    phase = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      program_phase(phase);
      phase_end = bytes_sent + $urandom_range(60, 160);
      while (bytes_sent < phase_end && bytes_sent < RANDOM_BYTES) begin
        send_random_line();
        if ($urandom_range(99) < 2) begin
          drain_results();
        end
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_lines.size() != 0) begin
      $error("%0d line results never arrived", expected_lines.size());
    end
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("line_pattern_matcher: match");
    end else begin
      $display("line_pattern_matcher: mismatch");
    end
    $finish;
  end

endmodule
